@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbt assertion failed");

`endif

@@ rtl/sbt_pkg.sv @@
`default_nettype none

package sbt_pkg;

    localparam int WINDOW  = 5;
    localparam int POS_W   = $clog2(WINDOW);
    localparam int SUM_W   = 32 + POS_W;

    localparam int IN_W    = 112;
    localparam int OUT_W   = 144;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W  = 48;
    localparam int ACC_W   = 49;
    localparam int INTEG_W = 34;

    localparam logic [9:0]  DROP_MARGIN_RST    = 10'd7;
    localparam logic [19:0] REFRESH_PERIOD_RST = 20'd5000;
    localparam logic [15:0] LATENCY_RST        = 16'd1500;
    localparam logic [19:0] READY_LIMIT_RST    = 20'd1000;
    localparam logic [15:0] PROP_GAIN_RST      = 16'd39322;
    localparam logic [15:0] INT_GAIN_RST       = 16'd2621;
    localparam logic [19:0] INTEGRAL_LIMIT_RST = 20'd100000;
    localparam logic [19:0] INT_LIMIT_MAX      = 20'd131071;
    localparam logic [9:0]  BASELINE_RST       = 10'd512;

    typedef enum logic [1:0] {
        OP_LASER = 2'd0,
        OP_SYNC  = 2'd1,
        OP_EVENT = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DROP_MARGIN    = 3'd0,
        CFG_REFRESH_PERIOD = 3'd1,
        CFG_LATENCY        = 3'd2,
        CFG_READY_LIMIT    = 3'd3,
        CFG_PROP_GAIN      = 3'd4,
        CFG_INT_GAIN       = 3'd5,
        CFG_INTEGRAL_LIMIT = 3'd6
    } cfg_idx_t;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_EXEC   = 9'b000000010,
        ST_ERR    = 9'b000000100,
        ST_MUL_I  = 9'b000001000,
        ST_ACC    = 9'b000010000,
        ST_CORR   = 9'b000100000,
        ST_SUM    = 9'b001000000,
        ST_CMP    = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

@@ rtl/sbt_mul.sv @@
`default_nettype none

module sbt_mul import sbt_pkg::*; (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [31:0]       a,
    input  logic [15:0]              b,
    output logic signed [PROD_W-1:0] prod_reg
);

    logic signed [PROD_W:0] full;

    always_comb
    begin
        full = a * $signed({1'b0, b});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= full[PROD_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/sync_slave_beam_timer_top.sv @@
// Sync slave beam timer.
// Input channel s_*: one item per packet or converter sample; s_tuser is the
// operation (laser sample, sync, event), s_tdata the times and level.
// Output channel m_*: one status item per input item; m_tuser marks an echo.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at once.
// Timing: laser, event, unused and first sync items go from the execute state
// straight to the finish state. A later sync with nonzero error makes two
// passes through the shared 32x16 multiplier, in states MUL_I and ACC; a zero
// error skips them. A sync that closes the window then adds the window one
// entry per cycle and compares. s_tready is high only while the sequencer
// idles, which it enters in the same cycle as the result turns valid.
// The result sits in an output register, so the next item is accepted while
// it waits; a stalled receiver holds m_tdata and delays only the finish of
// the following item.
// Reset: time base, servo, window, baseline (512) and counters return to
// their initial values and the configuration registers take their default settings.
`default_nettype none

module sync_slave_beam_timer_top import sbt_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,   // packet_time, now_us, now_ms, laser_level
    input  logic [1:0]           s_tuser,   // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_W-1:0]     m_tdata,   // synced, ready_res, sync_error, reaction_us,
                                            // beam_state, baseline_level, echo_time, time_base
    output logic                 m_tuser,   // echo_valid
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [9:0]  drop_margin_reg;
    logic [19:0] refresh_reg;
    logic [15:0] latency_reg;
    logic [19:0] rlimit_reg;
    logic [15:0] pgain_reg;
    logic [15:0] igain_reg;
    logic [19:0] ilimit_reg;

    logic [1:0]  op_reg;
    logic [31:0] ptime_reg;
    logic [31:0] nowus_reg;
    logic [31:0] nowms_reg;
    logic [9:0]  level_reg;

    state_t state_reg, state_next;
    logic [31:0] base_reg, base_next;
    logic        synced_reg, synced_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic [31:0] win_reg [WINDOW];
    logic [31:0] win_next [WINDOW];
    logic [POS_W-1:0] pos_reg, pos_next;
    logic        ready_reg, ready_next;
    logic [31:0] lasterr_reg, lasterr_next;
    logic [9:0]  baseline_reg, baseline_next;
    logic [31:0] lastref_reg, lastref_next;
    logic        broken_reg, broken_next;
    logic [31:0] evtime_reg, evtime_next;
    logic [31:0] evseen_reg, evseen_next;
    logic [31:0] evtimed_reg, evtimed_next;
    logic [31:0] react_reg, react_next;
    logic [31:0] err_reg, err_next;
    logic        wrap_reg, wrap_next;
    logic        echo_reg, echo_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [POS_W-1:0] idx_reg, idx_next;

    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] mdata_reg;
    logic             muser_reg;
    logic             out_load;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     mul_en;
    logic [15:0]              mul_gain;

    logic [31:0]        diff_ms;
    logic               refresh;
    logic [9:0]         base_lvl;
    logic signed [11:0] thr;
    logic               below;
    logic [31:0]        err_calc;
    logic [31:0]        mag;
    logic [POS_W-1:0]   pos_inc;
    logic [16:0]        lim17;
    logic signed [ACC_W-1:0] lim;
    logic signed [ACC_W-1:0] integ_ext;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] corr_up;
    logic [SUM_W-1:0]   ready_bound;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    assign mul_en   = (state_reg == ST_MUL_I) || (state_reg == ST_ACC);
    assign mul_gain = (state_reg == ST_ACC) ? pgain_reg : igain_reg;

    sbt_mul u_mul (
        .clk      (clk),
        .en       (mul_en),
        .a        ($signed(err_reg)),
        .b        (mul_gain),
        .prod_reg (prod_reg)
    );

    always_comb
    begin
        diff_ms  = nowms_reg - lastref_reg;
        refresh  = diff_ms > {12'd0, refresh_reg};
        base_lvl = refresh ? level_reg : baseline_reg;
        thr      = $signed({2'b00, base_lvl}) - $signed({2'b00, drop_margin_reg});
        below    = $signed({2'b00, level_reg}) < thr;
        err_calc = ptime_reg - nowus_reg + base_reg;
        mag      = err_reg[31] ? (~err_reg + 32'd1) : err_reg;
        pos_inc  = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
        lim17    = (ilimit_reg > INT_LIMIT_MAX) ? INT_LIMIT_MAX[16:0] : ilimit_reg[16:0];
        lim      = $signed({16'd0, lim17, 16'd0});
        integ_ext = {{(ACC_W - INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg};
        prod_ext  = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        acc_sum   = integ_ext + prod_ext;
        corr_up   = prod_ext + integ_ext + ACC_W'(65535);
        ready_bound = SUM_W'(rlimit_reg) * SUM_W'(WINDOW);
    end

    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        synced_next   = synced_reg;
        integ_next    = integ_reg;
        win_next      = win_reg;
        pos_next      = pos_reg;
        ready_next    = ready_reg;
        lasterr_next  = lasterr_reg;
        baseline_next = baseline_reg;
        lastref_next  = lastref_reg;
        broken_next   = broken_reg;
        evtime_next   = evtime_reg;
        evseen_next   = evseen_reg;
        evtimed_next  = evtimed_reg;
        react_next    = react_reg;
        err_next      = err_reg;
        wrap_next     = wrap_reg;
        echo_next     = echo_reg;
        sum_next      = sum_reg;
        idx_next      = idx_reg;
        out_load      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                echo_next  = 1'b0;
                state_next = ST_FINISH;
                case (op_reg)
                    OP_LASER:
                    begin
                        if (refresh)
                        begin
                            baseline_next = level_reg;
                            lastref_next  = nowms_reg;
                        end
                        if (!broken_reg && below)
                        begin
                            broken_next = 1'b1;
                            if ((evtime_reg != 32'd0) && (evseen_reg - 32'd1 == evtimed_reg))
                            begin
                                react_next   = nowus_reg - base_reg - evtime_reg;
                                evtimed_next = evtimed_reg + 32'd1;
                            end
                        end
                        else if (broken_reg && !below)
                        begin
                            broken_next = 1'b0;
                        end
                    end
                    OP_SYNC:
                    begin
                        if (!synced_reg)
                        begin
                            base_next   = nowus_reg - ptime_reg - {16'd0, latency_reg};
                            synced_next = 1'b1;
                        end
                        else
                        begin
                            err_next   = err_calc;
                            state_next = ST_ERR;
                        end
                    end
                    OP_EVENT:
                    begin
                        evtime_next = ptime_reg;
                        evseen_next = evseen_reg + 32'd1;
                        echo_next   = 1'b1;
                    end
                    default:
                    begin
                        echo_next = 1'b0;
                    end
                endcase
            end
            ST_ERR:
            begin
                lasterr_next      = err_reg;
                win_next[pos_reg] = mag;
                pos_next          = pos_inc;
                wrap_next         = (pos_inc == '0);
                sum_next          = '0;
                idx_next          = '0;
                if (err_reg != 32'd0)
                begin
                    state_next = ST_MUL_I;
                end
                else if (pos_inc == '0)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_I:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (acc_sum > lim)
                begin
                    integ_next = lim[INTEG_W-1:0];
                end
                else if (acc_sum < -lim)
                begin
                    integ_next = INTEG_W'(-lim);
                end
                else
                begin
                    integ_next = acc_sum[INTEG_W-1:0];
                end
                state_next = ST_CORR;
            end
            ST_CORR:
            begin
                base_next  = base_reg - corr_up[47:16];
                state_next = wrap_reg ? ST_SUM : ST_FINISH;
            end
            ST_SUM:
            begin
                sum_next = sum_reg + SUM_W'(win_reg[idx_reg]);
                if (idx_reg == POS_W'(WINDOW - 1))
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_CMP:
            begin
                ready_next = sum_reg < ready_bound;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_margin_reg <= DROP_MARGIN_RST;
            refresh_reg     <= REFRESH_PERIOD_RST;
            latency_reg     <= LATENCY_RST;
            rlimit_reg      <= READY_LIMIT_RST;
            pgain_reg       <= PROP_GAIN_RST;
            igain_reg       <= INT_GAIN_RST;
            ilimit_reg      <= INTEGRAL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DROP_MARGIN:    drop_margin_reg <= cfg_wdata[9:0];
                CFG_REFRESH_PERIOD: refresh_reg     <= cfg_wdata;
                CFG_LATENCY:        latency_reg     <= cfg_wdata[15:0];
                CFG_READY_LIMIT:    rlimit_reg      <= cfg_wdata;
                CFG_PROP_GAIN:      pgain_reg       <= cfg_wdata[15:0];
                CFG_INT_GAIN:       igain_reg       <= cfg_wdata[15:0];
                CFG_INTEGRAL_LIMIT: ilimit_reg      <= cfg_wdata;
                default:            ilimit_reg      <= ilimit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            base_reg     <= '0;
            synced_reg   <= 1'b0;
            integ_reg    <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
            pos_reg      <= '0;
            ready_reg    <= 1'b0;
            lasterr_reg  <= '0;
            baseline_reg <= BASELINE_RST;
            lastref_reg  <= '0;
            broken_reg   <= 1'b0;
            evtime_reg   <= '0;
            evseen_reg   <= '0;
            evtimed_reg  <= '0;
            react_reg    <= '0;
            wrap_reg     <= 1'b0;
            echo_reg     <= 1'b0;
            idx_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            synced_reg   <= synced_next;
            integ_reg    <= integ_next;
            win_reg      <= win_next;
            pos_reg      <= pos_next;
            ready_reg    <= ready_next;
            lasterr_reg  <= lasterr_next;
            baseline_reg <= baseline_next;
            lastref_reg  <= lastref_next;
            broken_reg   <= broken_next;
            evtime_reg   <= evtime_next;
            evseen_reg   <= evseen_next;
            evtimed_reg  <= evtimed_next;
            react_reg    <= react_next;
            wrap_reg     <= wrap_next;
            echo_reg     <= echo_next;
            idx_reg      <= idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
        sum_reg <= sum_next;
        if (s_tvalid && s_tready)
        begin
            op_reg    <= s_tuser;
            ptime_reg <= s_tdata[31:0];
            nowus_reg <= s_tdata[63:32];
            nowms_reg <= s_tdata[95:64];
            level_reg <= s_tdata[105:96];
        end
        if (out_load)
        begin
            mdata_reg <= {3'd0, base_reg, (echo_reg ? ptime_reg : 32'd0), baseline_reg,
                          broken_reg, react_reg, lasterr_reg, ready_reg, synced_reg};
            muser_reg <= echo_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sbt_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module sbt_checker import sbt_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_W-1:0]     m_tdata,
    input logic                 m_tuser
);

    `SBT_ASSERT_NXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `SBT_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `SBT_ASSERT_IMP(a_echo_zero, clk, rst_n, m_tvalid && !m_tuser, m_tdata[108:77] == 32'd0)
    `SBT_ASSERT_IMP(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[143:141] == 3'd0)

endmodule

bind sync_slave_beam_timer_top sbt_checker u_sbt_checker (.*);

`default_nettype wire
